// File: design/sla_pkg.sv
// ----------------------------------------------------------------------------
// Sound level averager package
// Widths, codes and the full-scale mapping function shared by the averager.
// ----------------------------------------------------------------------------
`default_nettype none

package sla_pkg;

   // Ring depth must be a power of two so that the average is a shift.
   localparam int AVG_DEPTH   = 16;
   localparam int SAMPLE_BITS = 12;
   localparam int SLOT_BITS   = $clog2(AVG_DEPTH);
   localparam int SUM_BITS    = SAMPLE_BITS + SLOT_BITS;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 12;

   // Mapped outputs (dB and percent) are 7 bits wide.
   localparam int MAP_BITS  = 7;
   localparam int PROD_BITS = SAMPLE_BITS + MAP_BITS;
   localparam int REM_BITS  = SAMPLE_BITS + 1;

   localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = {SAMPLE_BITS{1'b1}};
   localparam logic [MAP_BITS-1:0]    DB_LOW     = 7'd30;
   localparam logic [MAP_BITS-1:0]    DB_SPAN    = 7'd60;
   localparam logic [MAP_BITS-1:0]    PCT_SPAN   = 7'd100;
   localparam logic [SAMPLE_BITS-1:0] THRESHOLD_RESET = 12'd2000;

   typedef enum logic {
      KIND_TICK  = 1'b0,
      KIND_CLEAR = 1'b1
   } kind_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SOUND_ENABLE    = 2'd0,
      CSR_POT_ENABLE      = 2'd1,
      CSR_SOUND_THRESHOLD = 2'd2
   } csr_index_type;

   // Divides a product by the full scale value (2^SAMPLE_BITS - 1). With
   // prod = hi * 2^N + lo we have prod = hi * FULL_SCALE + (hi + lo), and
   // hi + lo stays below twice the full scale, so one correction suffices.
   function automatic logic [MAP_BITS-1:0] div_full_scale(
      input logic [PROD_BITS-1:0] prod
   );
      logic [MAP_BITS-1:0] hi;
      logic [REM_BITS-1:0] rem;
      hi  = prod[PROD_BITS-1:SAMPLE_BITS];
      rem = {1'b0, prod[SAMPLE_BITS-1:0]} + REM_BITS'(hi);
      if (rem >= REM_BITS'(FULL_SCALE)) begin
         return hi + 1'b1;
      end
      return hi;
   endfunction

endpackage

`default_nettype wire

// File: design/sound_level_averager_unit.sv
// ----------------------------------------------------------------------------
// Sound level averager unit
// Sixteen-sample moving average of a sound reading with peak hold, dB and
// threshold mapping, and a potentiometer reading mapped to percent.
// ----------------------------------------------------------------------------
//
// Usage:
//   A word on the req_ channel is either a sample tick (req_kind = KIND_TICK),
//   carrying one sound and one potentiometer reading, or a clear (KIND_CLEAR)
//   that zeroes the held peak. Every accepted word yields exactly one rsp_
//   word holding the current level, peak, dB value, threshold flag, pot value
//   and pot percent. Parts that are disabled in the csr_ registers keep their
//   last outputs; the threshold flag is low for clears and disabled ticks.
//
//   The accepting edge loads the first stage, which moves into the result
//   register when it advances and sets rsp_valid. Throughput is one word per
//   cycle while the receiver does not stall: the ring, the running sum and
//   the new average are updated as the word enters the first stage; the result
//   register updates the peak and maps the level and pot value with a constant
//   multiply and one correction.
//   Synchronous reset clears the sample ring, the running sum, all held
//   values and the valid flags of both pipeline stages; the threshold returns
//   to 2000 and both enables to zero. When the receiver stalls, the result
//   register holds and the first stage fills, after which req_ready drops
//   until rsp_ready rises. The csr_ channel is always ready and is written only
//   while the unit is idle, a rule on the user that the unit does not enforce.
`default_nettype none

module sound_level_averager_unit
   import sla_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,

   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_wdata,

   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic                      req_kind,
   input  wire logic [SAMPLE_BITS-1:0]    req_sound_sample,
   input  wire logic [SAMPLE_BITS-1:0]    req_pot_sample,

   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic [SAMPLE_BITS-1:0]         rsp_sound_level,
   output logic [SAMPLE_BITS-1:0]         rsp_sound_peak,
   output logic [MAP_BITS-1:0]            rsp_sound_db,
   output logic                           rsp_over_threshold,
   output logic [SAMPLE_BITS-1:0]         rsp_pot_value,
   output logic [MAP_BITS-1:0]            rsp_pot_percent
);

   // Configuration registers.
   logic                   sound_enable_ff;
   logic                   pot_enable_ff;
   logic [SAMPLE_BITS-1:0] sound_threshold_ff;

   // Averaging ring and running sum.
   logic [SAMPLE_BITS-1:0] ring_ff [AVG_DEPTH];
   logic [SLOT_BITS-1:0]   write_slot_ff;
   logic [SUM_BITS-1:0]    ring_sum_ff;
   logic [SUM_BITS-1:0]    ring_sum_in;

   // First stage.
   logic                   s1_valid_ff;
   logic                   s1_valid_in;
   logic                   s1_clear_ff;
   logic                   s1_sound_ff;
   logic                   s1_pot_ff;
   logic [SAMPLE_BITS-1:0] s1_level_ff;
   logic [SAMPLE_BITS-1:0] s1_pot_sample_ff;

   // Result register, which is also the held output state.
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [SAMPLE_BITS-1:0] level_ff;
   logic [SAMPLE_BITS-1:0] peak_ff;
   logic [SAMPLE_BITS-1:0] peak_in;
   logic [MAP_BITS-1:0]    db_ff;
   logic                   over_ff;
   logic [SAMPLE_BITS-1:0] pot_ff;
   logic [MAP_BITS-1:0]    pct_ff;

   logic                   req_accept;
   logic                   s1_advance;
   logic                   sound_tick;
   logic [PROD_BITS-1:0]   db_prod;
   logic [PROD_BITS-1:0]   pct_prod;

   // ------------------------------------------------------------------------
   // Configuration port. Writes to an index beyond the list are dropped.
   // ------------------------------------------------------------------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sound_enable_ff    <= 1'b0;
         pot_enable_ff      <= 1'b0;
         sound_threshold_ff <= THRESHOLD_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SOUND_ENABLE:    sound_enable_ff    <= csr_wdata[0];
            CSR_POT_ENABLE:      pot_enable_ff      <= csr_wdata[0];
            CSR_SOUND_THRESHOLD: sound_threshold_ff <= csr_wdata[SAMPLE_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Handshake. The first stage moves on whenever the result register is
   // empty or being drained, so a word can then enter in every cycle.
   // ------------------------------------------------------------------------
   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_advance;
   assign req_accept = req_valid && req_ready;

   always_comb begin
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      if (s1_advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ------------------------------------------------------------------------
   // First stage: the new sample replaces the oldest ring entry, and the
   // running sum is corrected by the difference of the two.
   // ------------------------------------------------------------------------
   assign sound_tick  = req_accept && (req_kind == KIND_TICK) && sound_enable_ff;
   assign ring_sum_in = ring_sum_ff - SUM_BITS'(ring_ff[write_slot_ff])
                        + SUM_BITS'(req_sound_sample);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < AVG_DEPTH; i++) begin
            ring_ff[i] <= '0;
         end
         write_slot_ff <= '0;
         ring_sum_ff   <= '0;
      end else if (sound_tick) begin
         ring_ff[write_slot_ff] <= req_sound_sample;
         write_slot_ff          <= write_slot_ff + 1'b1;
         ring_sum_ff            <= ring_sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_clear_ff      <= (req_kind == KIND_CLEAR);
         s1_sound_ff      <= (req_kind == KIND_TICK) && sound_enable_ff;
         s1_pot_ff        <= (req_kind == KIND_TICK) && pot_enable_ff;
         s1_pot_sample_ff <= req_pot_sample;
         // The level only matters when the sound path is enabled.
         s1_level_ff      <= sound_tick ? ring_sum_in[SUM_BITS-1:SLOT_BITS]
                                        : ring_sum_ff[SUM_BITS-1:SLOT_BITS];
      end
   end

   // ------------------------------------------------------------------------
   // Second stage: peak hold and the two linear mappings.
   // ------------------------------------------------------------------------
   assign db_prod  = PROD_BITS'(s1_level_ff) * PROD_BITS'(DB_SPAN);
   assign pct_prod = PROD_BITS'(s1_pot_sample_ff) * PROD_BITS'(PCT_SPAN);

   always_comb begin
      if (s1_clear_ff) begin
         peak_in = '0;
      end else if (s1_sound_ff && (s1_level_ff > peak_ff)) begin
         peak_in = s1_level_ff;
      end else begin
         peak_in = peak_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
         peak_ff  <= '0;
         db_ff    <= '0;
         over_ff  <= 1'b0;
         pot_ff   <= '0;
         pct_ff   <= '0;
      end else if (s1_advance) begin
         peak_ff <= peak_in;
         over_ff <= s1_sound_ff && (s1_level_ff > sound_threshold_ff);
         if (s1_sound_ff) begin
            level_ff <= s1_level_ff;
            db_ff    <= div_full_scale(db_prod) + DB_LOW;
         end
         if (s1_pot_ff) begin
            pot_ff <= s1_pot_sample_ff;
            pct_ff <= div_full_scale(pct_prod);
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_sound_level    = level_ff;
   assign rsp_sound_peak     = peak_ff;
   assign rsp_sound_db       = db_ff;
   assign rsp_over_threshold = over_ff;
   assign rsp_pot_value      = pot_ff;
   assign rsp_pot_percent    = pct_ff;

   // ------------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------------
   a_clear_zeroes_peak: assert property (@(posedge clock) disable iff (reset)
      (s1_advance && s1_clear_ff) |=> (rsp_sound_peak == '0))
      else $error("clear word did not zero the held peak");

   a_level_tracks_sum: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> (s1_level_ff == ring_sum_ff[SUM_BITS-1:SLOT_BITS]))
      else $error("staged level differs from the running sum average");

   a_db_range: assert property (@(posedge clock) disable iff (reset)
      (db_ff == '0) || ((db_ff >= DB_LOW) && (db_ff <= DB_LOW + DB_SPAN)))
      else $error("dB value outside its mapped range");

   a_pct_range: assert property (@(posedge clock) disable iff (reset)
      pct_ff <= PCT_SPAN)
      else $error("pot percent above full scale");

endmodule

`default_nettype wire
